### design/keyword_substitution_cipher_top_macros.svh
// Assertion macros shared by the cipher block
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define KWSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define KWSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/kwsc_pkg.sv
package kwsc_pkg;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_FINAL   = 2'd2,
      ACT_ENCRYPT = 2'd3
   } action_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   localparam logic [7:0] LETTER_A = 8'h61;

   // Commands from the sequencer to the key store
   typedef struct packed {
      logic clear;
      logic add;
      logic set_final;
      logic fill_step;
   } ks_cmd_type;

   // Status from the key store to the sequencer
   typedef struct packed {
      logic finalized;
      logic full;
   } ks_stat_type;

endpackage

### design/kwsc_keystore.sv
module kwsc_keystore #(
   parameter int ALPHABET_SIZE = 26,
   parameter int IDX_W         = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kwsc_pkg::ks_cmd_type   cmd,
   input  logic [IDX_W-1:0]       key_letter,
   input  logic [IDX_W-1:0]       walk_idx,
   input  logic [IDX_W-1:0]       lookup_idx,
   output logic [IDX_W-1:0]       lookup_data,
   output kwsc_pkg::ks_stat_type  stat
);
   import kwsc_pkg::*;

   localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

   logic [ALPHABET_SIZE-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic                     fin_ff, fin_in;
   logic [IDX_W-1:0]         table_ff [ALPHABET_SIZE];
   logic [IDX_W-1:0]         table_in [ALPHABET_SIZE];
   logic                     full;
   logic [IDX_W-1:0]         slot;

   assign full = (len_ff == CNT_W'(ALPHABET_SIZE));
   assign slot = len_ff[IDX_W-1:0];

   // Write the next key slot on an add or a fill step; set_final marks the key final
   always_comb begin
      mask_in  = mask_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      table_in = table_ff;
      if (cmd.set_final) begin
         fin_in = 1'b1;
      end
      if (cmd.add && !fin_ff && !mask_ff[key_letter] && !full) begin
         mask_in[key_letter] = 1'b1;
         table_in[slot]      = key_letter;
         len_in              = len_ff + 1'b1;
      end else if (cmd.fill_step && !mask_ff[walk_idx] && !full) begin
         table_in[slot] = walk_idx;
         len_in         = len_ff + 1'b1;
      end
   end

   // Hold the key; clear restores the identity table
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         mask_ff <= '0;
         len_ff  <= '0;
         fin_ff  <= 1'b0;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            table_ff[i] <= IDX_W'(i);
         end
      end else begin
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
         table_ff <= table_in;
      end
   end

   assign lookup_data    = table_ff[lookup_idx];
   assign stat.finalized = fin_ff;
   assign stat.full      = full;

endmodule

### design/kwsc_ctrl.sv
module kwsc_ctrl #(
   parameter int ALPHABET_SIZE = 26,
   parameter int IDX_W         = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  kwsc_pkg::action_type   action,
   input  logic                   in_alpha,
   input  kwsc_pkg::ks_stat_type  stat,
   output kwsc_pkg::ks_cmd_type   cmd,
   output logic [IDX_W-1:0]       walk_idx,
   output logic                   busy
);
   import kwsc_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic             start_walk;

   assign start_walk = accept && (action == ACT_FINAL) && !stat.finalized;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_walk) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_ff == '0 || stat.full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and walk counter
   always_comb begin
      cmd       = '0;
      walk_in   = walk_ff;
      busy      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.clear     = accept && (action == ACT_CLEAR);
            cmd.add       = accept && (action == ACT_ADD) && in_alpha;
            cmd.set_final = start_walk;
            walk_in       = IDX_W'(ALPHABET_SIZE - 1);
         end
         ST_WALK: begin
            cmd.fill_step = 1'b1;
            busy          = 1'b1;
            walk_in       = walk_ff - 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   assign walk_idx = walk_ff;

endmodule

### design/keyword_substitution_cipher_top.sv
// Channel | Ports                                         | Direction
// req     | req_valid req_ready req_action req_byte_value | in
// rsp     | rsp_valid rsp_ready rsp_cipher_byte           | out
//
// Clear, add and encrypt act on the request as it is taken; encrypt reads the key table and
// lands in the output register. Finalize sets the final flag, then walks the key:
// one slot-fill step per letter, walking down from the last letter.
// Reset (synchronous) empties the key and loads the identity table at once.
// Input is held off during the walk and while a result waits on rsp_ready.
`include "keyword_substitution_cipher_top_macros.svh"

module keyword_substitution_cipher_top #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_cipher_byte
);
   import kwsc_pkg::*;

   localparam int IDX_W = $clog2(ALPHABET_SIZE);

   action_type       action;
   logic             accept;
   logic             busy;
   logic [7:0]       offset;
   logic             in_alpha;
   logic [IDX_W-1:0] letter;
   logic [IDX_W-1:0] walk_idx;
   logic [IDX_W-1:0] lookup_data;
   ks_cmd_type       cmd;
   ks_stat_type      stat;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   assign action    = action_type'(req_action);
   assign req_ready = !busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Decode the byte into a letter index
   assign offset   = req_byte_value - LETTER_A;
   assign in_alpha = (req_byte_value >= LETTER_A) && (offset < 8'(ALPHABET_SIZE));
   assign letter   = in_alpha ? offset[IDX_W-1:0] : '0;

   kwsc_ctrl #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .action   (action),
      .in_alpha (in_alpha),
      .stat     (stat),
      .cmd      (cmd),
      .walk_idx (walk_idx),
      .busy     (busy)
   );

   kwsc_keystore #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .IDX_W         (IDX_W)
   ) u_keystore (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .key_letter  (letter),
      .walk_idx    (walk_idx),
      .lookup_idx  (letter),
      .lookup_data (lookup_data),
      .stat        (stat)
   );

   // Load the result on an encrypt transfer, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && (action == ACT_ENCRYPT)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = in_alpha ? (LETTER_A + 8'(lookup_data)) : req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_byte = rsp_data_ff;

   `KWSC_ASSERT_NOW(a_walk_blocks_req, busy, !req_ready, "request taken during key walk")
   `KWSC_ASSERT_NOW(a_walk_after_final, busy, stat.finalized, "key walk without finalize")
   `KWSC_ASSERT_NEXT(a_encrypt_gives_rsp, accept && (action == ACT_ENCRYPT), rsp_valid, "encrypt gave no result")
   `KWSC_ASSERT_NEXT(a_final_starts_walk, cmd.set_final, busy, "finalize did not start key walk")

endmodule

### sim/keyword_substitution_cipher_top_test.sv
`timescale 1ns / 100ps

module keyword_substitution_cipher_top_test;
   import kwsc_pkg::*;

   localparam int ALPHA = 26;
   localparam int APPLIED_TARGET = 1450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int DIRECTED_ROWS = 25;

   // Directed stimulus row; want is only used where known is set
   typedef struct packed {
      action_type act;
      logic [7:0] value;
      logic       known;
      logic [7:0] want;
   } step_row;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   action_type req_action = ACT_CLEAR;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_cipher_byte;

   // Predicted key state
   logic [25:0] key_mask;
   logic [4:0]  key_count;
   logic [4:0]  key_table [0:25];
   logic        key_done;

   logic [7:0] expected_cipher_q [$];
   int         applied_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   logic       steady = 1'b0;

   step_row    directed_rows [0:DIRECTED_ROWS-1];

   keyword_substitution_cipher_top #(
      .ALPHABET_SIZE(ALPHA)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cipher_byte(rsp_cipher_byte)
   );

   always #6 clock = ~clock;

   // Empty the key and load the identity table
   task automatic cipher_clear();
      key_mask = '0;
      key_count = '0;
      key_done = 1'b0;
      for (int i = 0; i < ALPHA; i++) key_table[i] = 5'(i);
   endtask

   // Apply one request to the predicted key; flag whether it did anything
   task automatic cipher_apply(input action_type act, input logic [7:0] value,
                               output logic has_out, output logic [7:0] enc,
                               output logic counts);
      int   idx;
      int   slot;
      logic is_letter;
      is_letter = (value >= LETTER_A) && (int'(value) - int'(LETTER_A) < ALPHA);
      idx = int'(value) - int'(LETTER_A);
      has_out = 1'b0;
      enc = value;
      counts = 1'b0;
      case (act)
         ACT_CLEAR: begin
            cipher_clear();
            counts = 1'b1;
         end
         ACT_ADD: begin
            // Drop letters outside the alphabet, repeats, and adds after finalize
            if (!key_done && is_letter) begin
               if (!key_mask[idx] && key_count < ALPHA) begin
                  key_mask[idx] = 1'b1;
                  key_table[key_count] = 5'(idx);
                  key_count = key_count + 5'd1;
                  counts = 1'b1;
               end
            end
         end
         ACT_FINAL: begin
            // Fill the free slots with unused letters, walking down from the last
            if (!key_done) begin
               slot = int'(key_count);
               for (int j = ALPHA - 1; j >= 0; j--) begin
                  if (slot < ALPHA && !key_mask[j]) begin
                     key_table[slot] = 5'(j);
                     slot++;
                  end
               end
               key_done = 1'b1;
               counts = 1'b1;
            end
         end
         default: begin
            has_out = 1'b1;
            counts = 1'b1;
            if (is_letter) enc = LETTER_A + 8'(key_table[idx]);
         end
      endcase
   endtask

   function automatic logic [7:0] random_letter();
      return LETTER_A + 8'($urandom_range(0, ALPHA - 1));
   endfunction

   function automatic logic [7:0] random_plain();
      if ($urandom_range(0, 99) < 85) return random_letter();
      return 8'($urandom_range(0, 255));
   endfunction

   // Present one request, hold it until the transfer, then predict its result
   task automatic send_request(input action_type act, input logic [7:0] value,
                               input logic known, input logic [7:0] want);
      logic       has_out;
      logic [7:0] enc;
      logic       counts;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_byte_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cipher_apply(act, value, has_out, enc, counts);
      if (has_out) expected_cipher_q.push_back(known ? want : enc);
      if (counts) applied_count++;
   endtask

   // Build one key from a random keyword, then encrypt a run of bytes
   task automatic keyed_sequence();
      int         key_len;
      int         letters [0:25];
      int         pick;
      int         tmp;
      logic [7:0] key_byte;
      send_request(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
      if ($urandom_range(0, 9) == 0) begin
         // Full keyword: every letter in random order, then a repeat
         for (int i = 0; i < ALPHA; i++) letters[i] = i;
         for (int i = ALPHA - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = letters[i];
            letters[i] = letters[pick];
            letters[pick] = tmp;
         end
         for (int i = 0; i < ALPHA; i++)
            send_request(ACT_ADD, LETTER_A + 8'(letters[i]), 1'b0, 8'h00);
         send_request(ACT_ADD, random_letter(), 1'b0, 8'h00);
      end else begin
         key_len = $urandom_range(0, 10);
         for (int i = 0; i < key_len; i++) begin
            key_byte = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : random_letter();
            send_request(ACT_ADD, key_byte, 1'b0, 8'h00);
         end
      end
      // Sometimes encrypt against a partial table
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) send_request(ACT_ENCRYPT, random_plain(), 1'b0, 8'h00);
      send_request(ACT_FINAL, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
      if ($urandom_range(0, 5) == 0) send_request(ACT_FINAL, random_letter(), 1'b0, 8'h00);
      if ($urandom_range(0, 5) == 0) send_request(ACT_ADD, random_letter(), 1'b0, 8'h00);
      repeat ($urandom_range(4, 20)) send_request(ACT_ENCRYPT, random_plain(), 1'b0, 8'h00);
   endtask

   // Stall the result side at random, except during the steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 11);
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cipher_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h",
                     $time, rsp_cipher_byte);
            error_count++;
         end else begin
            want = expected_cipher_q.pop_front();
            if (rsp_cipher_byte !== want) begin
               $display("%0t: cipher_byte mismatch, expected %h, actual %h",
                        $time, want, rsp_cipher_byte);
               error_count++;
            end
         end
      end
   end

   // End a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int pick;
      cipher_clear();
      directed_rows = '{
         '{ACT_ENCRYPT, 8'h61, 1'b1, 8'h61},
         '{ACT_ENCRYPT, 8'h7A, 1'b1, 8'h7A},
         '{ACT_ENCRYPT, 8'h00, 1'b1, 8'h00},
         '{ACT_ENCRYPT, 8'hFF, 1'b1, 8'hFF},
         '{ACT_ENCRYPT, 8'h60, 1'b1, 8'h60},
         '{ACT_ENCRYPT, 8'h7B, 1'b1, 8'h7B},
         '{ACT_ENCRYPT, 8'h41, 1'b1, 8'h41},
         '{ACT_ADD,     8'h6B, 1'b0, 8'h00},
         '{ACT_ADD,     8'h65, 1'b0, 8'h00},
         '{ACT_ADD,     8'h79, 1'b0, 8'h00},
         '{ACT_ADD,     8'h65, 1'b0, 8'h00},
         '{ACT_ADD,     8'h4B, 1'b0, 8'h00},
         '{ACT_ADD,     8'h80, 1'b0, 8'h00},
         '{ACT_ENCRYPT, 8'h61, 1'b1, 8'h6B},
         '{ACT_ENCRYPT, 8'h63, 1'b1, 8'h79},
         '{ACT_ENCRYPT, 8'h64, 1'b1, 8'h64},
         '{ACT_FINAL,   8'h00, 1'b0, 8'h00},
         '{ACT_FINAL,   8'hFF, 1'b0, 8'h00},
         '{ACT_ADD,     8'h62, 1'b0, 8'h00},
         '{ACT_ENCRYPT, 8'h64, 1'b0, 8'h00},
         '{ACT_ENCRYPT, 8'h7A, 1'b0, 8'h00},
         '{ACT_ENCRYPT, 8'h62, 1'b0, 8'h00},
         '{ACT_CLEAR,   8'hAA, 1'b0, 8'h00},
         '{ACT_ENCRYPT, 8'h62, 1'b1, 8'h62},
         '{ACT_ENCRYPT, 8'h7F, 1'b1, 8'h7F}
      };

      // Hold reset, then release it between edges
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].act, directed_rows[i].value,
                      directed_rows[i].known, directed_rows[i].want);

      // Mostly keyed sequences, the rest random requests of any kind
      while (applied_count < APPLIED_TARGET) begin
         steady = (applied_count >= 600 && applied_count < 800);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            keyed_sequence();
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(action_type'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), 1'b0, 8'h00);
         end
      end
      steady = 1'b0;

      // Drop valid and drain the remaining results
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cipher_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
